### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the name code encoder unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NSCE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NSCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/nsce_pkg.sv
// ----------------------------------------------------------------------------
// nsce_pkg
// Types and constants shared by the name code encoder modules.
// ----------------------------------------------------------------------------
package nsce_pkg;

   localparam logic [31:0] HASH_MUL    = 32'd54059;
   localparam logic [31:0] BYTE_MUL    = 32'd76963;
   localparam logic [31:0] HASH_SEED   = 32'd37;
   localparam logic [7:0]  BACKSLASH   = 8'h5C;
   localparam logic [2:0]  PACK_LENGTH = 3'd5;
   localparam logic [2:0]  MAX_LENGTH  = 3'd6;

   // Kinds of code carried with each result.
   localparam logic        KIND_PACKED = 1'b0;
   localparam logic        KIND_HASHED = 1'b1;

   // Hash contribution of a kept backslash byte.
   localparam logic [31:0] BACKSLASH_TERM = 32'(32'h0000_005C * BYTE_MUL);

   // Per-name accumulation state. The alt field holds the hash as it would be
   // with a held backslash already kept.
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] alt;
      logic [24:0] digits;
      logic [2:0]  len;
      logic        packable;
      logic        pending;
   } state_type;

   localparam state_type STATE_RESET = '{
      hash:     HASH_SEED,
      alt:      32'd0,
      digits:   25'd0,
      len:      3'd0,
      packable: 1'b1,
      pending:  1'b0
   };

   // Code assembled for a finished name.
   typedef struct packed {
      logic [30:0] code;
      logic        kind;
   } result_type;

endpackage

### hdl/nsce_update.sv
// ----------------------------------------------------------------------------
// nsce_update
// Next-state logic for one transaction: escape handling, lowering, the
// multiply-xor hash step, digit packing and code assembly for a final byte.
// ----------------------------------------------------------------------------
module nsce_update (
   input  nsce_pkg::state_type  state_cur,
   input  logic [7:0]           name_byte,
   input  logic                 byte_absent,
   input  logic                 final_byte,
   output nsce_pkg::state_type  state_nxt,
   output nsce_pkg::result_type result
);

   function automatic logic [7:0] lower_byte(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   function automatic logic is_escapable(input logic [7:0] b);
      return (b == 8'h5C) || (b == 8'h7B) || (b == 8'h7D) || (b == 8'h28) ||
             (b == 8'h29) || (b == 8'h5B) || (b == 8'h5D);
   endfunction

   function automatic logic [2:0] sat_inc(input logic [2:0] l);
      return (l < nsce_pkg::MAX_LENGTH) ? l + 3'd1 : l;
   endfunction

   logic [7:0]          kept;
   logic                keep_en;
   logic                use_alt;
   logic                to_alt;
   logic [31:0]         base;
   logic [31:0]         prod;
   logic [2:0]          len_base;
   logic                pack_ok;
   logic [4:0]          digit;
   logic [24:0]         digits_new;
   nsce_pkg::state_type nx;

   assign kept = lower_byte(name_byte);

   always_comb begin
      keep_en = 1'b0;
      use_alt = 1'b0;
      to_alt  = 1'b0;
      if (!byte_absent) begin
         if (state_cur.pending) begin
            keep_en = 1'b1;
            // Outside the escape set the held backslash is kept first.
            use_alt = !is_escapable(name_byte);
         end else if (name_byte == nsce_pkg::BACKSLASH && !final_byte) begin
            to_alt = 1'b1;
         end else begin
            keep_en = 1'b1;
         end
      end
   end

   assign base = use_alt ? state_cur.alt : state_cur.hash;
   assign prod = 32'(base * nsce_pkg::HASH_MUL) ^
                 32'({{24{kept[7]}}, kept} * nsce_pkg::BYTE_MUL);

   // A kept backslash is never packable, so it only bumps the length.
   assign len_base = use_alt ? sat_inc(state_cur.len) : state_cur.len;
   assign pack_ok  = (kept == 8'h20) || (kept >= 8'h5F && kept <= 8'h7D);
   assign digit    = (kept == 8'h20) ? 5'd0 : 5'(kept - 8'h5F);

   always_comb begin
      digits_new = state_cur.digits;
      case (len_base)
         3'd0:    digits_new[4:0]   = state_cur.digits[4:0]   | digit;
         3'd1:    digits_new[9:5]   = state_cur.digits[9:5]   | digit;
         3'd2:    digits_new[14:10] = state_cur.digits[14:10] | digit;
         3'd3:    digits_new[19:15] = state_cur.digits[19:15] | digit;
         3'd4:    digits_new[24:20] = state_cur.digits[24:20] | digit;
         default: digits_new        = state_cur.digits;
      endcase
   end

   always_comb begin
      nx = state_cur;
      if (keep_en) begin
         nx.pending  = 1'b0;
         nx.hash     = prod;
         nx.len      = sat_inc(len_base);
         nx.packable = state_cur.packable && !use_alt && pack_ok;
         if (pack_ok && len_base < nsce_pkg::PACK_LENGTH) begin
            nx.digits = digits_new;
         end
      end
      if (to_alt) begin
         nx.pending = 1'b1;
         nx.alt     = prod;
      end
      // A backslash still held when the name ends is kept as is.
      if (final_byte && byte_absent && state_cur.pending) begin
         nx.pending  = 1'b0;
         nx.hash     = state_cur.alt;
         nx.len      = sat_inc(state_cur.len);
         nx.packable = 1'b0;
      end
   end

   always_comb begin
      if (nx.packable && nx.len < nsce_pkg::MAX_LENGTH) begin
         result.code = {1'b1, 5'd0, nx.digits};
         result.kind = nsce_pkg::KIND_PACKED;
      end else begin
         result.code = {2'b11, nx.hash[28:0]};
         result.kind = nsce_pkg::KIND_HASHED;
      end
   end

   assign state_nxt = final_byte ? nsce_pkg::STATE_RESET : nx;

endmodule

### hdl/name_string_code_encoder_unit.sv
// ----------------------------------------------------------------------------
// name_string_code_encoder_unit
// Turns a name, presented one byte per req transaction, into a 31-bit code.
// The req channel carries a byte, a flag for an item without a byte and a
// flag marking the last item of the name. Only the last item of a name
// produces a rsp transaction: a packed code (kind 0) for short names of
// space and 0x5F..0x7D bytes, a hashed code (kind 1) otherwise.
// An accepted item lands in an input register; from there one pass of
// escape, lowering and a single multiply-xor hash step updates the name
// state and, for a last item, loads the rsp register that drives rsp_valid.
// Throughput is one item per cycle, set by the single hash recurrence step
// per byte, as long as no final item is held in the input register.
// While the rsp register holds an untaken code, non-final items still flow;
// a final item waits in the input register, and req_ready drops only then.
// Synchronous reset empties both registers and returns the name state to
// its initial values; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module name_string_code_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_name_byte,
   input  logic        req_byte_absent,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_name_code,
   output logic        rsp_code_kind
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_absent_ff;
   logic                 in_final_ff;
   logic                 advance;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [30:0]          rsp_code_ff;
   logic                 rsp_kind_ff;
   nsce_pkg::state_type  state_ff;
   nsce_pkg::state_type  state_in;
   nsce_pkg::state_type  state_calc;
   nsce_pkg::result_type result;

   // A non-final item never needs the rsp register.
   assign advance   = in_valid_ff && (!in_final_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_final_ff) || (rsp_valid_ff && !rsp_ready);
   assign state_in     = advance ? state_calc : state_ff;

   nsce_update u_update (
      .state_cur   (state_ff),
      .name_byte   (in_byte_ff),
      .byte_absent (in_absent_ff),
      .final_byte  (in_final_ff),
      .state_nxt   (state_calc),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= nsce_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff   <= req_name_byte;
         in_absent_ff <= req_byte_absent;
         in_final_ff  <= req_final_byte;
      end
      if (advance && in_final_ff) begin
         rsp_code_ff <= result.code;
         rsp_kind_ff <= result.kind;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_name_code = rsp_code_ff;
   assign rsp_code_kind = rsp_kind_ff;

   // The name state starts over after the last byte of a name is processed.
   `NSCE_ASSERT_NEXT(a_state_cleared, clock, reset, advance && in_final_ff,
      state_ff == nsce_pkg::STATE_RESET, "name state not cleared after final byte")

   // While a backslash is held, the alternate hash is the backslash step.
   `NSCE_ASSERT_IMPLIES(a_alt_hash, clock, reset, state_ff.pending,
      state_ff.alt == (32'(state_ff.hash * nsce_pkg::HASH_MUL) ^ nsce_pkg::BACKSLASH_TERM),
      "alternate hash out of step with held backslash")

   // Packed codes carry the short tag, hashed codes the hash tag.
   `NSCE_ASSERT_IMPLIES(a_code_tag, clock, reset, rsp_valid_ff,
      rsp_code_ff[30] && (rsp_code_ff[29] == rsp_kind_ff),
      "code tag does not match code kind")

   // A final item stalled in the input register means the rsp side is full.
   `NSCE_ASSERT_IMPLIES(a_stall_cause, clock, reset, in_valid_ff && !advance,
      in_final_ff && rsp_valid_ff && !rsp_ready, "input stall without cause")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for name_string_code_encoder_unit. Names are sent one
// byte per req transaction; a monitor feeds every accepted transaction to a
// behavioral copy of the encoder, and each rsp transaction is compared with
// the oldest predicted code. The sender idles in bursts, and the receiver
// stalls in several patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [30:0] PACKED_BASE = 31'h4000_0000;
   localparam logic [31:0] HASH_MASK   = 32'h1FFF_FFFF;
   localparam logic [31:0] HASH_TAG    = 32'h6000_0000;
   localparam logic [7:0]  SPACE_CHAR  = 8'h20;
   localparam logic [7:0]  ESCAPABLE [7] = '{8'h5C, 8'h7B, 8'h7D, 8'h28, 8'h29,
                                             8'h5B, 8'h5D};
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 300;

   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_name_byte = 8'h00;
   logic        req_byte_absent = 1'b0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [30:0] rsp_name_code;
   logic        rsp_code_kind;

   name_string_code_encoder_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_name_byte   (req_name_byte),
      .req_byte_absent (req_byte_absent),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_name_code   (rsp_name_code),
      .rsp_code_kind   (rsp_code_kind)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted name state, updated on every accepted req transaction.
   logic [31:0] name_hash;
   logic [24:0] name_digits;
   logic [2:0]  name_len;
   logic        name_packable;
   logic        name_held_backslash;

   nsce_pkg::result_type pending_codes[$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          packed_seen = 0;
   int          hashed_seen = 0;
   int          burst_left = 0;
   bit          sender_gaps = 1'b0;
   rx_mode_type rx_mode = RX_ALWAYS;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   function automatic void clear_name();
      name_hash = nsce_pkg::HASH_SEED;
      name_digits = '0;
      name_len = '0;
      name_packable = 1'b1;
      name_held_backslash = 1'b0;
   endfunction

   function automatic bit is_escapable(input logic [7:0] c);
      foreach (ESCAPABLE[i])
         if (ESCAPABLE[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   // Folds one byte that survived escape removal into the hash and digits.
   function automatic void absorb_byte(input logic [7:0] raw);
      logic [7:0]  c;
      logic [31:0] widened;
      logic [4:0]  digit;
      c = raw;
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      widened = {{24{c[7]}}, c};
      name_hash = (name_hash * nsce_pkg::HASH_MUL) ^ (widened * nsce_pkg::BYTE_MUL);
      if (c == SPACE_CHAR || (c >= 8'h5F && c <= 8'h7D)) begin
         digit = (c == SPACE_CHAR) ? 5'd0 : 5'(c - 8'h5F);
         if (name_len < nsce_pkg::PACK_LENGTH)
            name_digits = name_digits | (25'(digit) << (5 * name_len));
      end else begin
         name_packable = 1'b0;
      end
      if (name_len < nsce_pkg::MAX_LENGTH) name_len = name_len + 3'd1;
   endfunction

   function automatic void predict_name_code(input logic [7:0] b, input logic absent,
                                             input logic fin);
      nsce_pkg::result_type r;
      if (!absent) begin
         if (name_held_backslash) begin
            name_held_backslash = 1'b0;
            if (is_escapable(b)) begin
               absorb_byte(b);
            end else begin
               absorb_byte(nsce_pkg::BACKSLASH);
               absorb_byte(b);
            end
         end else if (b == nsce_pkg::BACKSLASH) begin
            name_held_backslash = 1'b1;
         end else begin
            absorb_byte(b);
         end
      end
      if (fin) begin
         // A backslash left hanging at the end of a name is an ordinary byte.
         if (name_held_backslash) begin
            name_held_backslash = 1'b0;
            absorb_byte(nsce_pkg::BACKSLASH);
         end
         if (name_packable && name_len < nsce_pkg::MAX_LENGTH) begin
            r.code = PACKED_BASE + 31'(name_digits);
            r.kind = nsce_pkg::KIND_PACKED;
         end else begin
            r.code = 31'((name_hash & HASH_MASK) | HASH_TAG);
            r.kind = nsce_pkg::KIND_HASHED;
         end
         pending_codes = {pending_codes, r};
         clear_name();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   initial clear_name();

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Every accepted req transaction updates the predicted name state.
   always @(posedge clock)
      if (!reset && req_valid && req_ready)
         predict_name_code(req_name_byte, req_byte_absent, req_final_byte);

   always @(posedge clock) begin
      nsce_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected code %h kind %0d",
                                      rsp_name_code, rsp_code_kind));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_name_code !== want.code)
               report_mismatch($sformatf("name_code %h, predicted %h",
                                         rsp_name_code, want.code));
            if (rsp_code_kind !== want.kind)
               report_mismatch($sformatf("code_kind %0d, predicted %0d",
                                         rsp_code_kind, want.kind));
            if (want.kind == nsce_pkg::KIND_PACKED) packed_seen++;
            else hashed_seen++;
         end
      end
   end

   // The receiver follows its own stall pattern, and on request holds off
   // for a long stretch so that the input side backs up.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:   rsp_ready <= 1'b1;
            RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: rsp_ready <= ((cycle_count % 7) < 2);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   task automatic send_item(input logic [7:0] b, input logic absent, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_name_byte <= b;
      req_byte_absent <= absent;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // An empty string becomes a single final transaction without a byte.
   task automatic send_name(input string s);
      if (s.len() == 0) begin
         send_item(8'h00, 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0, i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] pick_name_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'($urandom_range(8'h5F, 8'h7D));
         4:          return SPACE_CHAR;
         5:          return 8'($urandom_range(8'h41, 8'h5A));
         6:          return nsce_pkg::BACKSLASH;
         7:          return ESCAPABLE[$urandom_range(0, 6)];
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly short names, since those reach the packed path; some run long.
   task automatic send_random_name();
      int n;
      n = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 5) : $urandom_range(6, 12);
      if (n == 0) begin
         send_item(8'($urandom), 1'b1, 1'b1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b1, 1'b0);
         if (i == n - 1 && $urandom_range(0, 7) == 0) begin
            send_item(pick_name_byte(), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b1);
         end else begin
            send_item(pick_name_byte(), 1'b0, i == n - 1);
         end
      end
   endtask

   task automatic test_directed();
      sender_gaps = 1'b0;
      rx_mode = RX_ALWAYS;
      send_name("");
      send_item(8'hFF, 1'b1, 1'b0);
      send_name("A ");
      send_name("_}abc");
      send_name("abcdef");
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_name("\\{");
      send_name("\\q");
      send_name("z\\");
      send_item(nsce_pkg::BACKSLASH, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_random_names(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) begin
            sender_gaps = 1'($urandom_range(0, 1));
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         end
         send_random_name();
      end
   endtask

   task automatic test_backpressure();
      sender_gaps = 1'b0;
      rx_mode = RX_ALWAYS;
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) send_random_name();
      sender_gaps = 1'b1;
   endtask

   task automatic test_noise(input int count);
      sender_gaps = 1'b1;
      rx_mode = RX_MOSTLY;
      for (int i = 0; i < count; i++)
         send_item(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
      // Close any name the noise left open.
      send_item(8'h00, 1'b1, 1'b1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_names(600);
      test_backpressure();
      test_random_names(450);
      test_noise(320);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("tb: %0d transactions sent, %0d packed and %0d hashed codes checked",
               items_sent, packed_seen, hashed_seen);
      $display("tb: covered escapes, case folding, long names, noise and a long rsp stall");
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
